[src/wtms_pkg.sv]
// Shared types for the weighted midrank sum block.
package wtms_pkg;
  localparam int unsigned RiskW = 16;
  localparam int unsigned WgtW  = 16;
  localparam int unsigned SumW  = 23;
  localparam int unsigned IdxW  = 6;

  typedef struct packed {
    logic [RiskW-1:0] risk_value;
    logic             case_flag;
    logic             control_flag;
    logic [WgtW-1:0]  item_weight;
    logic             final_item;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0] record_index;
    logic [SumW-1:0] case_sum_twice;
    logic [SumW-1:0] control_sum_twice;
    logic            run_end;
  } out_word_t;

  // Entry of the risk-ordered store.
  typedef struct packed {
    logic [1:0]       flags;   // bit 1 control, bit 0 case
    logic [WgtW-1:0]  weight;
    logic [RiskW-1:0] risk;
    logic [IdxW-1:0]  idx;     // load position
  } entry_t;

  typedef enum logic [5:0] {
    ST_LOAD  = 6'b000001,
    ST_INS   = 6'b000010,
    ST_PREP  = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  // Controller commands and datapath status.
  typedef struct packed {
    logic store;      // take the input word and start its insertion
    logic ins;        // one insertion step
    logic prep;       // clear sweep pointers, fetch first sorted entry
    logic scan;       // accumulate tie group
    logic write;      // write one group result
    logic emit;       // present one result
  } cmd_t;

  typedef struct packed {
    logic ins_done;   // insertion point found
    logic set_last;   // inserted word ends the load
    logic grp_done;   // tie group fully scanned
    logic wr_done;    // group results written
    logic pass_done;  // sweep finished
    logic emit_last;
  } stat_t;
endpackage

[src/weighted_tie_midrank_sums_top.sv]
// Top level of the weighted midrank sum block.
//  channel | signals                    | direction
//  input   | start_i, busy_o, in_word_i | in
//  result  | done_o, out_word_o         | out
// A word is taken at an edge with start_i high and busy_o low; busy_o then stays high
// while it is inserted in risk order, past the stored records of higher risk. After
// the final word: a setup step, a sweep that scans each tie group and then writes its
// results, then n results on done_o one per cycle, the last one shown
// while busy_o is already low. Reset clears control state; results cannot be stalled.
module weighted_tie_midrank_sums_top import wtms_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_word_t  in_word_i,
  output logic      busy_o,
  output logic      done_o,
  output out_word_t out_word_o
);
  cmd_t  cmd;
  stat_t stat;

  wtms_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .stat_i(stat), .cmd_o(cmd), .busy_o
  );

  wtms_dp #(.MAX_ITEMS(MAX_ITEMS)) u_dp (
    .clk_i, .rst_ni, .word_i(in_word_i), .cmd_i(cmd), .stat_o(stat),
    .valid_o(done_o), .word_o(out_word_o)
  );
endmodule

[src/wtms_ctrl.sv]
// Controller state machine for the weighted midrank sum block.
module wtms_ctrl import wtms_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o,
  output logic  busy_o
);
  state_e state_q, state_d;

  // Advance state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Sequence load, insertion, sweep and result phases.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      ST_LOAD: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.store = 1'b1;
          state_d = ST_INS;
        end
      end
      ST_INS: begin
        cmd_o.ins = 1'b1;
        if (stat_i.ins_done) state_d = stat_i.set_last ? ST_PREP : ST_LOAD;
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.grp_done) state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        if (stat_i.wr_done) state_d = stat_i.pass_done ? ST_EMIT : ST_SCAN;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (stat_i.emit_last) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end
endmodule

[src/wtms_dp.sv]
// Datapath: stores, insertion sort and tie-grouped sweeps.
module wtms_dp import wtms_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_word_t  word_i,
  input  cmd_t      cmd_i,
  output stat_t     stat_o,
  output logic      valid_o,
  output out_word_t word_o
);
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned AW   = $clog2(MAX_ITEMS);

  // Risk-ordered store and per-record results, one registered read each.
  entry_t          ord_mem  [MAX_ITEMS];
  logic [SumW-1:0] csum_mem [MAX_ITEMS];
  logic [SumW-1:0] ksum_mem [MAX_ITEMS];

  entry_t           rd_q;     // ordered entry read in the previous cycle
  entry_t           key_q;    // entry being inserted
  logic [CntW-1:0]  cnt_q;    // loaded count
  logic [CntW-1:0]  j_q;      // insertion point / group scan
  logic [CntW-1:0]  l_q;      // group write / result pointer
  logic             last_q;   // word under insertion ends the load
  logic             gfirst_q;
  logic [RiskW-1:0] grisk_q;
  logic [SumW-1:0]  prev_c_q; // control weight below the group
  logic [SumW-1:0]  rem_k_q;  // case weight at or above the group
  logic [SumW-1:0]  tie_c_q, tie_k_q;
  logic [SumW-1:0]  base_c_q, base_k_q;

  logic [CntW-1:0]  cnt_inc;
  logic [AW-1:0]    raddr;
  logic             shift, in_grp;
  logic [SumW-1:0]  own_c, own_k;

  assign cnt_inc = cnt_q + CntW'(1);

  // Insertion: move entries up while their risk is larger than the key.
  assign shift = (j_q != '0) && (rd_q.risk > key_q.risk);
  // Sweep: an entry joins the group while its risk matches.
  assign in_grp = (j_q < cnt_q) && (gfirst_q || (rd_q.risk == grisk_q));

  assign stat_o.ins_done  = !shift;
  assign stat_o.set_last  = last_q;
  assign stat_o.grp_done  = !in_grp;
  assign stat_o.wr_done   = (l_q + CntW'(1) == j_q);
  assign stat_o.pass_done = (j_q == cnt_q);
  assign stat_o.emit_last = (l_q + CntW'(1) == cnt_q);

  assign own_c = rd_q.flags[1] ? SumW'(rd_q.weight) : '0;
  assign own_k = rd_q.flags[0] ? SumW'(rd_q.weight) : '0;

  // Select the ordered entry needed in the next cycle.
  always_comb begin
    raddr = '0;
    if (cmd_i.store)      raddr = AW'(cnt_q - CntW'(1));
    else if (cmd_i.ins)   raddr = AW'(j_q - CntW'(2));
    else if (cmd_i.scan)  raddr = in_grp ? AW'(j_q + CntW'(1)) : AW'(l_q);
    else if (cmd_i.write) raddr = AW'(l_q + CntW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      j_q      <= '0;
      l_q      <= '0;
      last_q   <= 1'b0;
      gfirst_q <= 1'b1;
      prev_c_q <= '0;
      rem_k_q  <= '0;
      tie_c_q  <= '0;
      tie_k_q  <= '0;
      valid_o  <= 1'b0;
    end else begin
      valid_o <= cmd_i.emit;
      // Count the word, add its case weight and start its insertion at the top.
      if (cmd_i.store) begin
        cnt_q  <= cnt_inc;
        j_q    <= cnt_q;
        last_q <= word_i.final_item || (cnt_inc >= CntW'(MAX_ITEMS));
        if (word_i.case_flag) rem_k_q <= rem_k_q + SumW'(word_i.item_weight);
      end
      if (cmd_i.ins && shift) j_q <= j_q - CntW'(1);
      // Clear sweep pointers and running sums.
      if (cmd_i.prep) begin
        j_q      <= '0;
        l_q      <= '0;
        gfirst_q <= 1'b1;
        prev_c_q <= '0;
        tie_c_q  <= '0;
        tie_k_q  <= '0;
      end
      // Accumulate the tie group, then fold it into the running sums.
      if (cmd_i.scan) begin
        if (in_grp) begin
          j_q      <= j_q + CntW'(1);
          gfirst_q <= 1'b0;
          if (rd_q.flags[1]) tie_c_q <= tie_c_q + SumW'(rd_q.weight);
          if (rd_q.flags[0]) tie_k_q <= tie_k_q + SumW'(rd_q.weight);
        end else begin
          gfirst_q <= 1'b1;
          prev_c_q <= prev_c_q + tie_c_q;
          rem_k_q  <= rem_k_q - tie_k_q;
          tie_c_q  <= '0;
          tie_k_q  <= '0;
        end
      end
      if (cmd_i.write) begin
        l_q <= (stat_o.wr_done && stat_o.pass_done) ? '0 : l_q + CntW'(1);
      end
      // Advance through results; the last one ends the set.
      if (cmd_i.emit) begin
        l_q <= l_q + CntW'(1);
        if (stat_o.emit_last) begin
          cnt_q   <= '0;
          rem_k_q <= '0;
        end
      end
    end
  end

  // Memories and payload registers.
  always_ff @(posedge clk_i) begin
    rd_q <= ord_mem[raddr];
    if (cmd_i.store) begin
      key_q.flags  <= {word_i.control_flag, word_i.case_flag};
      key_q.weight <= word_i.item_weight;
      key_q.risk   <= word_i.risk_value;
      key_q.idx    <= IdxW'(cnt_q);
    end
    if (cmd_i.ins) ord_mem[AW'(j_q)] <= shift ? rd_q : key_q;
    if (cmd_i.scan) begin
      if (in_grp) begin
        grisk_q <= rd_q.risk;
      end else begin
        base_c_q <= (prev_c_q << 1) + tie_c_q;
        base_k_q <= (rem_k_q << 1) - tie_k_q;
      end
    end
    if (cmd_i.write) begin
      csum_mem[AW'(rd_q.idx)] <= base_c_q - own_c;
      ksum_mem[AW'(rd_q.idx)] <= base_k_q - own_k;
    end
    if (cmd_i.emit) begin
      word_o.record_index      <= IdxW'(l_q);
      word_o.case_sum_twice    <= csum_mem[AW'(l_q)];
      word_o.control_sum_twice <= ksum_mem[AW'(l_q)];
      word_o.run_end           <= stat_o.emit_last;
    end
  end
endmodule

[src/wtms_checker.sv]
// Port-level checks for the weighted midrank sum block.
module wtms_checker import wtms_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input logic      done_o,
  input out_word_t out_word_o
);
  // A result only appears after a busy cycle.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result while idle");
  // First result of a run has index zero.
  a_first_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !$past(done_o) |-> out_word_o.record_index == '0)
    else $error("run did not start at index zero");
  // Indices count up within a run.
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(done_o) && !$past(out_word_o.run_end) |->
    out_word_o.record_index == $past(out_word_o.record_index) + 1'b1)
    else $error("index skipped");
  // Busy is low with the last result of a run.
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && out_word_o.run_end |-> !busy_o) else $error("busy after run end");
  // An accepted word raises busy for its insertion.
  a_take_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("busy low after accepted word");
endmodule

bind weighted_tie_midrank_sums_top wtms_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .out_word_o
);

[tb/weighted_tie_midrank_sums_top_tb.sv]
// Testbench for the weighted midrank sum block: random record sets checked against a predictor.
`timescale 1ns / 100ps

module weighted_tie_midrank_sums_top_tb;
  import wtms_pkg::*;

  localparam int unsigned MaxRecs = 64;

  logic      clk;
  logic      rst_n;
  logic      start;
  in_word_t  in_word;
  logic      busy;
  logic      done;
  out_word_t out_word;

  in_word_t  pending_words[$];
  out_word_t expected_sums[$];
  int unsigned error_count;
  int unsigned idle_pct;

  // Predictor copy of the record store
  logic [15:0] risk_mem[MaxRecs];
  logic [15:0] wgt_mem[MaxRecs];
  logic        case_mem[MaxRecs];
  logic        ctrl_mem[MaxRecs];
  int unsigned rec_count;

  weighted_tie_midrank_sums_top #(.MAX_ITEMS(MaxRecs)) u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .start_i   (start),
    .in_word_i (in_word),
    .busy_o    (busy),
    .done_o    (done),
    .out_word_o(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Store one record; on the last of a set, queue the midrank sums of every record.
  task automatic predict_midrank_sums(input in_word_t w);
    int unsigned n;
    logic [31:0] ctrl_lo, ctrl_eq, case_hi, case_eq;
    out_word_t r;
    risk_mem[rec_count] = w.risk_value;
    wgt_mem[rec_count]  = w.item_weight;
    case_mem[rec_count] = w.case_flag;
    ctrl_mem[rec_count] = w.control_flag;
    rec_count++;
    if (!(w.final_item || rec_count >= MaxRecs)) return;
    n = rec_count;
    for (int k = 0; k < n; k++) begin
      ctrl_lo = 0; ctrl_eq = 0; case_hi = 0; case_eq = 0;
      for (int j = 0; j < n; j++) begin
        if (ctrl_mem[j] && risk_mem[j] < risk_mem[k]) ctrl_lo += wgt_mem[j];
        if (ctrl_mem[j] && risk_mem[j] == risk_mem[k]) ctrl_eq += wgt_mem[j];
        if (case_mem[j] && risk_mem[j] > risk_mem[k]) case_hi += wgt_mem[j];
        if (case_mem[j] && risk_mem[j] == risk_mem[k]) case_eq += wgt_mem[j];
      end
      if (ctrl_mem[k]) ctrl_eq -= wgt_mem[k];
      if (case_mem[k]) case_eq -= wgt_mem[k];
      r.record_index      = k[5:0];
      r.case_sum_twice    = 23'(2 * ctrl_lo + ctrl_eq);
      r.control_sum_twice = 23'(2 * case_hi + case_eq);
      r.run_end           = (k + 1 == n);
      expected_sums.push_back(r);
    end
    rec_count = 0;
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  function automatic in_word_t make_record(input logic [15:0] risk, input logic is_case,
                                           input logic is_ctrl, input logic [15:0] wgt,
                                           input logic last);
    in_word_t w;
    w.risk_value   = risk;
    w.case_flag    = is_case;
    w.control_flag = is_ctrl;
    w.item_weight  = wgt;
    w.final_item   = last;
    return w;
  endfunction

  // Queue one random set; small sets, half of them with narrow risk ranges for ties.
  task automatic queue_random_set(input int unsigned len);
    int unsigned risk_span;
    logic [15:0] risk, wgt;
    risk_span = $urandom_range(0, 3);
    for (int i = 0; i < len; i++) begin
      case (risk_span)
        0: risk = 16'($urandom_range(0, 3));
        1: risk = 16'($urandom_range(0, 15)) << 12;
        default: risk = 16'($urandom);
      endcase
      wgt = ($urandom_range(0, 4) == 0) ? 16'hFFFF : 16'($urandom);
      pending_words.push_back(make_record(risk, 1'($urandom), 1'($urandom), wgt,
                                          i == len - 1));
    end
  endtask

  // Drive a word when one is pending, idling at random; hold a waiting word
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_word <= '0;
    end else begin
      if (start && !busy) begin
        predict_midrank_sums(in_word);
        void'(pending_words.pop_front());
      end
      if (!(start && busy)) begin
        if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start   <= 1'b1;
          in_word <= pending_words[0];
        end else begin
          start   <= 1'b0;
          in_word <= in_word_t'({$urandom, $urandom});
        end
      end
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && done) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("unexpected result word, index", out_word.record_index, -1);
      end else begin
        if (out_word.record_index != expected_sums[0].record_index)
          report_mismatch("record_index", out_word.record_index,
                          expected_sums[0].record_index);
        if (out_word.case_sum_twice != expected_sums[0].case_sum_twice)
          report_mismatch("case_sum_twice", out_word.case_sum_twice,
                          expected_sums[0].case_sum_twice);
        if (out_word.control_sum_twice != expected_sums[0].control_sum_twice)
          report_mismatch("control_sum_twice", out_word.control_sum_twice,
                          expected_sums[0].control_sum_twice);
        if (out_word.run_end != expected_sums[0].run_end)
          report_mismatch("run_end", out_word.run_end, expected_sums[0].run_end);
        void'(expected_sums.pop_front());
      end
    end
  end

  initial begin
    int unsigned phase_pct[4] = '{0, 49, 0, 17};
    rst_n       = 1'b0;
    error_count = 0;
    rec_count   = 0;
    idle_pct    = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, single flags, both, neither, ties, minimal set
    pending_words.push_back(make_record(16'h0000, 1'b1, 1'b0, 16'hFFFF, 1'b0));
    pending_words.push_back(make_record(16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0));
    pending_words.push_back(make_record(16'h8000, 1'b1, 1'b1, 16'h0100, 1'b0));
    pending_words.push_back(make_record(16'h8000, 1'b1, 1'b1, 16'h0001, 1'b0));
    pending_words.push_back(make_record(16'h8000, 1'b0, 1'b0, 16'h0000, 1'b0));
    pending_words.push_back(make_record(16'h5555, 1'b0, 1'b1, 16'hAAAA, 1'b1));
    pending_words.push_back(make_record(16'hAAAA, 1'b1, 1'b0, 16'h5555, 1'b0));
    pending_words.push_back(make_record(16'h1234, 1'b0, 1'b1, 16'h00FF, 1'b1));
    pending_words.push_back(make_record(16'h7777, 1'b1, 1'b1, 16'h8000, 1'b1));
    // Full store: the 64th record ends the set without a final flag
    for (int i = 0; i < MaxRecs; i++)
      pending_words.push_back(make_record(16'($urandom_range(0, 7)), 1'($urandom),
                                          1'($urandom), 16'hFFFF, 1'b0));

    // Random sets across idling phases
    for (int p = 0; p < 4; p++) begin
      idle_pct = phase_pct[p];
      while (pending_words.size() < 18) queue_random_set($urandom_range(1, 10));
      while (pending_words.size() != 0 || expected_sums.size() != 0) @(posedge clk);
    end
    pending_words.push_back(make_record(16'h0, 1'b1, 1'b1, 16'hFFFF, 1'b0));
    queue_random_set(2);
    while (pending_words.size() != 0 || expected_sums.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
